/* sv/ptt_pkg.sv */
// Shared constants, types and codes for the periodic timer table.
package ptt_pkg;

  localparam int SLOTS  = 32;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = 5;
  localparam int PER_W  = 16;
  localparam int ELA_W  = 17;
  localparam int STEP_W = 10;
  localparam int OP_W   = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ELA_W-1:0]  ELAPSED_MAX = {ELA_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_RST    = STEP_W'(10);

  // request opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_STEP = 1'b0;
  localparam logic REG_RUN  = 1'b1;

  typedef enum logic [2:0] {
    KIND_CREATED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DESTROYED = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_CREATE,
    S_DONE
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              adv;
    logic              clr;
    logic              tick_go;
    logic              create_go;
    logic [STEP_W-1:0] step;
    logic [PER_W-1:0]  period;
  } cell_cmd_t;

endpackage

/* sv/ptt_cell.sv */
// One timer slot: live flag, interval, elapsed count and scan token stage.
module ptt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ptt_pkg::cell_cmd_t  cmd,
  input  logic                kill,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                exp_o,
  output logic                free_o
);

  logic                        tok_r;
  logic                        live_r, live_nxt;
  logic [ptt_pkg::PER_W-1:0]   per_r;
  logic [ptt_pkg::ELA_W-1:0]   ela_r, ela_nxt;
  logic [ptt_pkg::ELA_W:0]     sum;
  logic [ptt_pkg::ELA_W-1:0]   ela_sat;
  logic                        hit;
  logic                        claim;

  assign sum     = {1'b0, ela_r} +
                   {{(ptt_pkg::ELA_W + 1 - ptt_pkg::STEP_W){1'b0}}, cmd.step};
  assign ela_sat = sum[ptt_pkg::ELA_W] ? ptt_pkg::ELAPSED_MAX : sum[ptt_pkg::ELA_W-1:0];
  assign hit     = (ela_sat >= {{(ptt_pkg::ELA_W - ptt_pkg::PER_W){1'b0}}, per_r});
  assign claim   = tok_r & cmd.create_go & ~live_r;

  assign tok_o  = tok_r;
  assign exp_o  = tok_r & live_r & hit;
  assign free_o = tok_r & ~live_r;

  always_comb begin
    live_nxt = live_r;
    ela_nxt  = ela_r;
    if (kill) begin
      live_nxt = 1'b0;
      ela_nxt  = '0;
    end else if (tok_r && cmd.tick_go && live_r) begin
      ela_nxt = hit ? '0 : ela_sat;
    end else if (claim) begin
      live_nxt = 1'b1;
      ela_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      live_r <= 1'b0;
      ela_r  <= '0;
    end else begin
      live_r <= live_nxt;
      ela_r  <= ela_nxt;
      if (cmd.clr) begin
        tok_r <= 1'b0;
      end else if (cmd.adv) begin
        tok_r <= tok_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      per_r <= cmd.period;
    end
  end

endmodule

/* sv/periodic_timer_table_unit.sv */
// Periodic timer table: a chain of slot cells swept by a token, one slot per cycle
//   unless a result waits on out_tready. Tick: accept, scan of all SLOTS slots and
//   tick-done result; a frozen tick (run_enable 0) skips the scan. Create: scan up
//   to the lowest free slot, else full after the last; destroy: accept, then done.
// Reset (synchronous, rst_n low): every slot free, counts zero, tick_step 10,
//   run_enable 0, no result pending. Slot intervals are not reset.
module periodic_timer_table_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // in_tuser: opcode[1:0]
  input  logic [ptt_pkg::OP_W-1:0]    in_tuser,
  // in_tdata: period[15:0], slot_id[20:16], zero[23:21]
  input  logic [23:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_tdata: slot[4:0], zero[7:5]
  output logic [7:0]                  out_tdata,
  // out_tuser: kind[2:0]
  output logic [2:0]                  out_tuser,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ptt_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ptt_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SLOTS  = ptt_pkg::SLOTS;
  localparam int IDX_W  = ptt_pkg::IDX_W;
  localparam int SLOT_W = ptt_pkg::SLOT_W;

  // input fields
  logic [ptt_pkg::OP_W-1:0]   in_op;
  logic [ptt_pkg::PER_W-1:0]  in_per;
  logic [SLOT_W-1:0]          in_sid;
  logic                       in_acc;

  assign in_op  = in_tuser;
  assign in_per = in_tdata[15:0];
  assign in_sid = in_tdata[20:16];
  assign in_acc = in_tvalid & in_tready;

  // configuration
  logic [ptt_pkg::STEP_W-1:0] step_r;
  logic                       run_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ptt_pkg::STEP_RST;
      run_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ptt_pkg::REG_STEP: step_r <= cfg_pwdata[ptt_pkg::STEP_W-1:0];
        ptt_pkg::REG_RUN:  run_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ptt_pkg::REG_STEP: cfg_prdata = {{(ptt_pkg::DATA_W - ptt_pkg::STEP_W){1'b0}}, step_r};
      ptt_pkg::REG_RUN:  cfg_prdata = {{(ptt_pkg::DATA_W - 1){1'b0}}, run_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // sequencer state
  ptt_pkg::state_t            state_r, state_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [ptt_pkg::PER_W-1:0]  per_r, per_nxt;
  ptt_pkg::kind_t             done_kind_r, done_kind_nxt;
  logic [SLOT_W-1:0]          done_slot_r, done_slot_nxt;

  // output register
  logic                       out_valid_r;
  ptt_pkg::kind_t             out_kind_r;
  logic [SLOT_W-1:0]          out_slot_r;
  logic                       out_last_r;
  logic                       out_free;
  logic                       ld;
  ptt_pkg::kind_t             ld_kind;
  logic [SLOT_W-1:0]          ld_slot;
  logic                       ld_last;

  // cell chain
  ptt_pkg::cell_cmd_t         cmd;
  logic                       inject;
  logic [SLOTS-1:0]           tok_v, exp_v, free_v, kill_v;
  logic                       any_exp, any_free, last_idx;

  assign out_free = ~out_valid_r | out_tready;
  assign any_exp  = |exp_v;
  assign any_free = |free_v;
  assign last_idx = (idx_r == IDX_W'(SLOTS - 1));

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic tok_in;
      if (g == 0) begin : g_head
        assign tok_in = inject;
      end else begin : g_link
        assign tok_in = tok_v[g-1];
      end
      assign kill_v[g] = in_acc && (in_op == ptt_pkg::OP_DESTROY) && (int'(in_sid) == g);
      ptt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .kill   (kill_v[g]),
        .tok_i  (tok_in),
        .tok_o  (tok_v[g]),
        .exp_o  (exp_v[g]),
        .free_o (free_v[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    per_nxt       = per_r;
    done_kind_nxt = done_kind_r;
    done_slot_nxt = done_slot_r;
    ld            = 1'b0;
    ld_kind       = ptt_pkg::KIND_TICK_DONE;
    ld_slot       = '0;
    ld_last       = 1'b1;
    inject        = 1'b0;
    cmd.adv       = 1'b1;
    cmd.clr       = 1'b0;
    cmd.tick_go   = 1'b0;
    cmd.create_go = 1'b0;
    cmd.step      = step_r;
    cmd.period    = per_r;
    in_tready     = (state_r == ptt_pkg::S_IDLE);

    unique case (state_r)
      ptt_pkg::S_IDLE: begin
        if (in_acc) begin
          priority case (in_op)
            ptt_pkg::OP_TICK: begin
              if (run_r) begin
                inject    = 1'b1;
                idx_nxt   = '0;
                state_nxt = ptt_pkg::S_TICK;
              end else begin
                done_kind_nxt = ptt_pkg::KIND_TICK_DONE;
                done_slot_nxt = '0;
                state_nxt     = ptt_pkg::S_DONE;
              end
            end
            ptt_pkg::OP_CREATE: begin
              inject    = 1'b1;
              idx_nxt   = '0;
              per_nxt   = in_per;
              state_nxt = ptt_pkg::S_CREATE;
            end
            ptt_pkg::OP_DESTROY: begin
              done_kind_nxt = ptt_pkg::KIND_DESTROYED;
              done_slot_nxt = in_sid;
              state_nxt     = ptt_pkg::S_DONE;
            end
            default: ;  // unused opcode: dropped
          endcase
        end
      end
      ptt_pkg::S_TICK: begin
        if (any_exp && !out_free) begin
          cmd.adv = 1'b0;  // hold the token until the expiry can go out
        end else begin
          cmd.tick_go = 1'b1;
          if (any_exp) begin
            ld      = 1'b1;
            ld_kind = ptt_pkg::KIND_EXPIRED;
            ld_slot = SLOT_W'(idx_r);
            ld_last = 1'b0;
          end
          if (last_idx) begin
            done_kind_nxt = ptt_pkg::KIND_TICK_DONE;
            done_slot_nxt = '0;
            state_nxt     = ptt_pkg::S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ptt_pkg::S_CREATE: begin
        cmd.adv = out_free;
        if (out_free) begin
          cmd.create_go = 1'b1;
          if (any_free) begin
            ld        = 1'b1;
            ld_kind   = ptt_pkg::KIND_CREATED;
            ld_slot   = SLOT_W'(idx_r);
            cmd.clr   = 1'b1;
            state_nxt = ptt_pkg::S_IDLE;
          end else if (last_idx) begin
            ld        = 1'b1;
            ld_kind   = ptt_pkg::KIND_FULL;
            cmd.clr   = 1'b1;
            state_nxt = ptt_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ptt_pkg::S_DONE: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = done_kind_r;
          ld_slot   = done_slot_r;
          state_nxt = ptt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ptt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_r       <= per_nxt;
    done_kind_r <= done_kind_nxt;
    done_slot_r <= done_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind_r <= ld_kind;
      out_slot_r <= ld_slot;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // at most one cell holds the scan token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v))
    else $error("more than one scan token in the chain");

  // no token left in the chain once the sequencer is idle
  a_idle_no_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::S_IDLE) |-> (tok_v == '0))
    else $error("scan token left behind in idle");

  // an expiry is never the closing result of a tick
  a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == ptt_pkg::KIND_EXPIRED)) |-> !out_last_r)
    else $error("expiry result marked last");

  // the sweep stalls only while an expiry waits for a free output register
  a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ptt_pkg::S_TICK) && !cmd.adv) |-> (any_exp && out_valid_r))
    else $error("tick sweep stalled without a pending expiry");

endmodule
